@@ design/wmm_pkg.sv @@
// ----------------------------------------------------------------------------
// wmm_pkg: shared definitions for the windowed min/max/mean core
// Port widths, reset constants, the window length clamp and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int IN_W             = 32;     // sample port width
    localparam int OUT_W            = 32;     // min, max and mean port width
    localparam int LEN_W            = 17;     // window length and count width
    localparam int WINDOW_RESET     = 16;     // window length after reset
    localparam int DEF_SAMPLE_BITS  = 32;
    localparam int DEF_MAX_WINDOW   = 65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a sample beat is taken this cycle
        logic snap;      // the taken sample closes the window
        logic prep;      // form numerator and denominator
        logic absval;    // load the dividend magnitude
        logic div_step;  // one restoring division step
        logic finish;    // apply the sign and register the mean
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;     // the next sample completes the window
    } t_dp_stat;

    // A length of zero means one sample; lengths above the maximum saturate.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input int unsigned max_len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(max_len)) begin
            res = LEN_W'(max_len);
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

@@ design/windowed_min_max_mean_core.sv @@
// ----------------------------------------------------------------------------
// windowed_min_max_mean_core: per-channel window statistics
// Reports minimum, maximum, rounded mean and count of each window of samples.
// ----------------------------------------------------------------------------
// Usage: one instance serves one sensor channel. Each input beat carries one
// signed sample on i_sample; the low SAMPLE_BITS bits are used. A beat is
// taken on a rising edge with i_in_valid high and o_in_stall low. Samples
// are accumulated at one beat per cycle with no gaps while o_in_stall is low. When the count reaches
// the window length, one report beat is produced on the output channel with
// the minimum, the maximum, trunc((2*sum + count) / (2*count)) and the count,
// and the window restarts empty.
// The mean comes from a restoring divider that resolves one quotient bit per
// cycle; after its closing sample a report passes the prep, magnitude,
// division and sign-fix states before it is offered on the output. The next
// window accumulates during that time; only the sample that would close the
// following window is stalled while a report is still being formed or held.
// If the receiver stalls, the report holds on the output port and the block
// keeps taking samples up to the next window's closing sample.
// The window length register is written through i_cfg_valid/i_cfg_data, is
// always ready, and must only be written while the block is idle. A length
// of zero acts as one and lengths above MAX_WINDOW saturate. Reset (i_rst_n
// low, synchronous) empties the window and sets the window length to 16.
// ----------------------------------------------------------------------------
module windowed_min_max_mean_core
    import wmm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Sample channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [IN_W-1:0]  i_sample,
    // Window length register write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_data,
    // Report channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_min_value,
    output logic signed [OUT_W-1:0] o_max_value,
    output logic signed [OUT_W-1:0] o_mean_value,
    output logic [LEN_W-1:0]        o_window_count
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The register is a single flop bank, so a write is always taken.
    assign o_cfg_ready = 1'b1;

    wmm_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    wmm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_mean_value   (o_mean_value),
        .o_window_count (o_window_count)
    );

endmodule

@@ design/wmm_datapath.sv @@
// ----------------------------------------------------------------------------
// wmm_datapath: accumulators, report snapshot and mean divider
// Keeps the running count, sum, minimum and maximum, takes a snapshot when a
// window closes and divides one quotient bit per step on that snapshot.
// ----------------------------------------------------------------------------
module wmm_datapath
    import wmm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [IN_W-1:0]  i_sample,
    input  logic                    i_cfg_we,
    input  logic [LEN_W-1:0]        i_cfg_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic signed [OUT_W-1:0] o_min_value,
    output logic signed [OUT_W-1:0] o_max_value,
    output logic signed [OUT_W-1:0] o_mean_value,
    output logic [LEN_W-1:0]        o_window_count
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int MAG_W = SUM_W + 1;
    localparam int DEN_W = CNT_W + 1;

    logic [CNT_W-1:0]              r_eff_len;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min, r_max, n_max;
    logic signed [SAMPLE_BITS-1:0] w_sample;

    logic signed [SUM_W-1:0]       r_snap_sum;
    logic [CNT_W-1:0]              r_snap_cnt;
    logic signed [SAMPLE_BITS-1:0] r_snap_min, r_snap_max;

    logic [MAG_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_den;
    logic                          r_neg;
    logic [MAG_W-1:0]              r_dvd;
    logic [DEN_W-1:0]              r_rem;
    logic [DEN_W+1:0]              w_trial;
    logic [MAG_W-1:0]              w_quot;
    logic signed [SAMPLE_BITS-1:0] w_mean;
    logic signed [OUT_W-1:0]       r_mean;

    assign w_sample = i_sample[SAMPLE_BITS-1:0];

    always_comb begin
        n_cnt = r_cnt + CNT_W'(1);
        n_sum = r_sum + SUM_W'(w_sample);
        n_min = ((r_cnt == '0) || (w_sample < r_min)) ? w_sample : r_min;
        n_max = ((r_cnt == '0) || (w_sample > r_max)) ? w_sample : r_max;
    end

    assign o_stat.close = (n_cnt >= r_eff_len);

    // Configuration holds the already clamped length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_len <= CNT_W'(clamp_len(LEN_W'(WINDOW_RESET), MAX_WINDOW));
        end else if (i_cfg_we) begin
            r_eff_len <= CNT_W'(clamp_len(i_cfg_data, MAX_WINDOW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else if (i_cmd.accept) begin
            if (i_cmd.snap) begin
                r_cnt <= '0;
                r_sum <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_min <= n_min;
            r_max <= n_max;
        end
        if (i_cmd.snap) begin
            r_snap_sum <= n_sum;
            r_snap_cnt <= n_cnt;
            r_snap_min <= n_min;
            r_snap_max <= n_max;
        end
    end

    // Restoring division of |2*sum + count| by 2*count.
    assign w_trial = {1'b0, r_rem, r_dvd[MAG_W-1]} - {2'b00, r_den};
    assign w_quot  = r_neg ? (MAG_W'(0) - r_dvd) : r_dvd;
    assign w_mean  = w_quot[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_num <= {r_snap_sum, 1'b0} + MAG_W'(r_snap_cnt);
            r_den <= {r_snap_cnt, 1'b0};
        end
        if (i_cmd.absval) begin
            r_neg <= r_num[MAG_W-1];
            r_dvd <= r_num[MAG_W-1] ? (MAG_W'(0) - r_num) : r_num;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_trial[DEN_W+1]) begin
                r_rem <= {r_rem[DEN_W-2:0], r_dvd[MAG_W-1]};
                r_dvd <= {r_dvd[MAG_W-2:0], 1'b0};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_dvd <= {r_dvd[MAG_W-2:0], 1'b1};
            end
        end
        if (i_cmd.finish) begin
            r_mean <= OUT_W'(w_mean);
        end
    end

    // The snapshot only changes when a window closes, which cannot happen
    // while a report is pending, so the result fields read it directly.
    assign o_min_value    = OUT_W'(r_snap_min);
    assign o_max_value    = OUT_W'(r_snap_max);
    assign o_mean_value   = r_mean;
    assign o_window_count = LEN_W'(r_snap_cnt);

    a_cnt_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(MAX_WINDOW))
        else $error("sample count reached the window maximum without a report");

endmodule

@@ design/wmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmm_ctrl: report sequencer
// Lets samples through, stalls the window closing sample while a report is
// still in flight and steps the datapath through the mean division.
// ----------------------------------------------------------------------------
module wmm_ctrl
    import wmm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int MAG_W  = SAMPLE_BITS + CNT_W + 1;
    localparam int STEP_W = $clog2(MAG_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    assign o_in_stall = (r_state != S_IDLE) && i_stat.close;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd.accept    = w_accept;
        o_cmd.snap      = w_accept && i_stat.close;
        o_cmd.prep      = 1'b0;
        o_cmd.absval    = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.finish    = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.snap) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_ABS;
            end
            S_ABS: begin
                o_cmd.absval = 1'b1;
                n_step       = STEP_W'(MAG_W - 1);
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_snap_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.snap |-> (r_state == S_IDLE))
        else $error("window closed while a report was in flight");

    a_fix_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> ($past(r_state) == S_DIV && $past(r_step) == '0))
        else $error("mean finished before the last division step");

    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_stall) |=> (r_state == S_IDLE))
        else $error("report taken but sequencer did not return to idle");

endmodule

@@ tb/windowed_min_max_mean_core_tb.sv @@
// ----------------------------------------------------------------------------
// windowed_min_max_mean_core_tb: self-checking bench for the window statistics
// Sends signed sample beats under random gaps and receiver stalls. It keeps
// its own running count, sum, minimum and maximum, predicts every report, and
// compares each report beat field by field against the oldest report due.
// ----------------------------------------------------------------------------
module windowed_min_max_mean_core_tb;
    import wmm_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    // The divider resolves one quotient bit per cycle, with the prep, magnitude and fix states around it.
    localparam int REPORT_LATENCY = DEF_SAMPLE_BITS + $clog2(DEF_MAX_WINDOW + 1) + 4;
    localparam int SETTLE_CYCLES  = 2 * REPORT_LATENCY;
    localparam int SATURATE_SAMPLES = 40;
    localparam int RANDOM_SAMPLES = 720;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int MAX_SHOWN      = 10;

    localparam logic signed [IN_W-1:0] SAMPLE_MIN = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic signed [IN_W-1:0] SAMPLE_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic [LEN_W-1:0]       LEN_ALL_ONES = '1;

    // One report as the block should emit it.
    typedef struct {
        logic signed [OUT_W-1:0] min_value;
        logic signed [OUT_W-1:0] max_value;
        logic signed [OUT_W-1:0] mean_value;
        logic [LEN_W-1:0]        window_count;
    } t_window_report;

    // Every input starts at a known value before the first clock edge.
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic signed [IN_W-1:0]  i_sample    = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [LEN_W-1:0]        i_cfg_data  = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_cfg_ready;
    logic                    o_out_valid;
    logic signed [OUT_W-1:0] o_min_value;
    logic signed [OUT_W-1:0] o_max_value;
    logic signed [OUT_W-1:0] o_mean_value;
    logic [LEN_W-1:0]        o_window_count;

    // Shadow of the block's state, starting from its reset values.
    logic [LEN_W-1:0]        win_len   = LEN_W'(WINDOW_RESET);
    logic [LEN_W-1:0]        acc_count = '0;
    logic signed [47:0]      acc_sum   = '0;
    logic signed [OUT_W-1:0] acc_min   = '0;
    logic signed [OUT_W-1:0] acc_max   = '0;

    t_window_report          reports_due[$];
    logic signed [IN_W-1:0]  sample_backlog[$];

    // The sender and the receiver draw their pauses from zero up to these bounds.
    // A bound of zero gives a stretch with back-to-back beats on that side.
    int unsigned             in_gap_max    = 4;
    int unsigned             out_stall_max = 4;
    int unsigned             in_wait       = 0;
    int unsigned             stall_left    = 0;
    longint unsigned         samples_queued = 0;
    longint unsigned         samples_taken  = 0;
    longint unsigned         reports_seen   = 0;
    longint unsigned         cycles         = 0;
    int unsigned             errors         = 0;

    windowed_min_max_mean_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_mean_value   (o_mean_value),
        .o_window_count (o_window_count)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Folds one accepted sample into the shadow window. When the count reaches
    // the effective length, the report is queued and the window starts empty.
    // A length of zero behaves as one, and lengths above the largest window
    // saturate. Because the check is "at or above", a length lowered while a
    // window is half full closes that window on the very next sample.
    function automatic void accumulate_sample(input logic signed [IN_W-1:0] s);
        logic [LEN_W-1:0] eff_len;
        longint           numer;
        longint           denom;
        t_window_report   rpt;
        if (acc_count == '0) begin
            acc_min = s;
            acc_max = s;
        end else begin
            if (s < acc_min) acc_min = s;
            if (s > acc_max) acc_max = s;
        end
        acc_sum   = acc_sum + s;
        acc_count = acc_count + 1'b1;
        if (win_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (win_len > LEN_W'(DEF_MAX_WINDOW)) begin
            eff_len = LEN_W'(DEF_MAX_WINDOW);
        end else begin
            eff_len = win_len;
        end
        if (acc_count >= eff_len) begin
            // Mean plus one half, with the division truncating toward zero.
            numer = 2 * longint'(acc_sum) + longint'(acc_count);
            denom = 2 * longint'(acc_count);
            rpt.min_value    = acc_min;
            rpt.max_value    = acc_max;
            rpt.mean_value   = OUT_W'(numer / denom);
            rpt.window_count = acc_count;
            reports_due.push_back(rpt);
            acc_count = '0;
            acc_sum   = '0;
            acc_min   = '0;
            acc_max   = '0;
        end
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function automatic void compare_field(input string field,
                                          input logic signed [63:0] got,
                                          input logic signed [63:0] want);
        if (got !== want) begin
            flag_error($sformatf("report %0d: %s expected %0d, got %0d",
                                 reports_seen, field, want, got));
        end
    endfunction

    // Mix of extremes, values near zero, moderate values and full-range noise.
    function automatic logic signed [IN_W-1:0] pick_sample();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return IN_W'(int'($urandom_range(0, 16)) - 8);
            4, 5:    return IN_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly short windows so that reports are frequent. Full 17-bit values
    // give long or saturated lengths; their windows are closed later when a
    // following phase lowers the length.
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return '0;
            1, 2:    return LEN_W'($urandom_range(1, 3));
            3, 4, 5: return LEN_W'($urandom_range(4, 12));
            6, 7:    return LEN_W'($urandom_range(13, 64));
            default: return LEN_W'($urandom());
        endcase
    endfunction

    task automatic queue_sample(input logic signed [IN_W-1:0] s);
        sample_backlog.push_back(s);
        samples_queued++;
    endtask

    // Waits until every queued beat has been taken and every report is back,
    // then lets the divider drain before anything else touches the block.
    task automatic settle();
        while (samples_taken != samples_queued || reports_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_len = len;
    endtask

    // Sample driver. A beat is taken on an edge where valid is high and the
    // block does not stall. The next beat is presented only once the current
    // one is gone, after the gap drawn for it, so a stalled payload holds.
    always @(posedge i_clk) begin : sample_driver
        logic taken;
        taken = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else begin
            if (taken) begin
                accumulate_sample(i_sample);
                samples_taken++;
            end
            if (!i_in_valid || taken) begin
                if (in_wait != 0) begin
                    i_in_valid <= 1'b0;
                    in_wait    <= in_wait - 1;
                end else if (sample_backlog.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_sample   <= sample_backlog.pop_front();
                    in_wait    <= $urandom_range(0, in_gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor. Each accepted report beat is checked against the oldest
    // report due. After every beat the receiver draws a stall length; while
    // waiting it also stalls now and then, so that stalls meet reports the
    // moment they appear as well as later.
    always @(posedge i_clk) begin : report_monitor
        int unsigned    hold;
        t_window_report want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                reports_seen++;
                if (reports_due.size() == 0) begin
                    flag_error($sformatf(
                        "report %0d arrived with none due: min %0d max %0d mean %0d count %0d",
                        reports_seen, o_min_value, o_max_value, o_mean_value,
                        o_window_count));
                end else begin
                    want = reports_due.pop_front();
                    compare_field("min_value", o_min_value, want.min_value);
                    compare_field("max_value", o_max_value, want.max_value);
                    compare_field("mean_value", o_mean_value, want.mean_value);
                    compare_field("window_count", o_window_count, want.window_count);
                end
                hold = $urandom_range(0, out_stall_max);
            end else if (stall_left != 0) begin
                hold = stall_left - 1;
            end else if (out_stall_max != 0 && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, out_stall_max);
            end else begin
                hold = 0;
            end
            stall_left  <= hold;
            i_out_stall <= (hold != 0);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("windowed_min_max_mean_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset length of 16 closes one window built from the extremes.
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample('0);
        queue_sample(-1);
        queue_sample(1);
        repeat (11) queue_sample(pick_sample());
        settle();

        // A length of zero acts as one: each sample is reported by itself,
        // including the rounding of the most negative sample toward zero.
        write_window_length('0);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        settle();

        // A window of the largest samples gives the largest possible mean.
        write_window_length(LEN_W'(3));
        repeat (3) queue_sample(SAMPLE_MAX);
        settle();

        // Lowering the length under a half-full window closes it on the next
        // sample, so this report counts four samples against a length of two.
        write_window_length(LEN_W'(8));
        repeat (3) queue_sample(pick_sample());
        settle();
        write_window_length(LEN_W'(2));
        queue_sample(pick_sample());
        settle();

        // An all-ones length saturates to the largest window, so a run of
        // mostly most-negative samples stays open. A length of one then
        // closes that window on the next sample.
        write_window_length(LEN_ALL_ONES);
        repeat (SATURATE_SAMPLES) begin
            queue_sample(($urandom_range(0, 4) == 0) ? pick_sample() : SAMPLE_MIN);
        end
        settle();
        write_window_length(LEN_W'(1));
        queue_sample(SAMPLE_MIN);
        settle();

        // Random phases: a new length and new pacing for each short burst.
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            write_window_length(pick_length());
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 4;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            n = $urandom_range(5, 40);
            repeat (n) queue_sample(pick_sample());
            sent += n;
            settle();
        end

        if (errors == 0) begin
            $display("windowed_min_max_mean_core verification clean");
        end else begin
            $display("windowed_min_max_mean_core verification failed");
        end
        $finish;
    end

endmodule
